// File: sv/smpd_pkg.sv
`timescale 1ns / 1ps

package smpd_pkg;

    // Field widths
    localparam int SAMPLE_W = 10;
    localparam int AGE_W    = 4;
    localparam int IN_W     = 16;
    localparam int OUT_W    = 16;

    localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 10'd600;

    // One window entry: value plus age (0 = newest)
    typedef struct packed {
        logic [SAMPLE_W-1:0] val;
        logic [AGE_W-1:0]    age;
    } cell_t;

    // Broadcast control from the top level to every cell
    typedef struct packed {
        logic                accept;
        logic                prime;
        logic [SAMPLE_W-1:0] sample;
        logic [AGE_W-1:0]    age_max;
    } cell_ctl_t;

endpackage

// File: sv/sliding_median_press_detector.sv
`timescale 1ns / 1ps
// The result word is registered as its sample is accepted and appears in the next cycle.
// Throughput: one word per cycle unless the output stalls; the whole row of
// cells drops the oldest entry and inserts the new sample in the same cycle.
// Reset (rst_n low, async): output empty, threshold back to 600, window
// unprimed; the first sample after reset fills every cell.
module sliding_median_press_detector
    import smpd_pkg::*;
#(
    parameter int WINDOW = 5
)
(
    input  logic                clk,
    input  logic                rst_n,
    // tdata: [9:0] sample
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [IN_W-1:0]     s_tdata,
    // tdata: [9:0] median, [10] pressed
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_W-1:0]    m_tdata,
    // threshold register write
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [SAMPLE_W-1:0] cfg_data
);

    localparam int MID = WINDOW / 2;

    cell_ctl_t           ctl;
    cell_t               cell_q [WINDOW];
    cell_t               cell_n [WINDOW];
    cell_t               cell_w [WINDOW];
    logic [WINDOW-1:0]   w_ok;
    logic [WINDOW-1:0]   del;
    logic                accept;

    logic                primed_reg;
    logic [SAMPLE_W-1:0] thr_reg;
    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] median_reg;
    logic                pressed_reg;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign ctl.accept  = accept;
    assign ctl.prime   = !primed_reg;
    assign ctl.sample  = s_tdata[SAMPLE_W-1:0];
    assign ctl.age_max = AGE_W'(WINDOW - 1);

    // Row of cells, each talking to its left and right neighbors where present
    for (genvar i = 0; i < WINDOW; i++)
    begin : g_cell
        cell_t left_w;
        logic  left_ok;
        cell_t right_c;
        logic  right_ok;
        logic  del_in;

        if (i == 0)
        begin : g_first
            assign left_w  = '0;
            assign left_ok = 1'b0;
            assign del_in  = 1'b0;
        end
        else
        begin : g_inner
            assign left_w  = cell_w[i-1];
            assign left_ok = w_ok[i-1];
            assign del_in  = del[i-1];
        end

        if (i == WINDOW - 1)
        begin : g_last
            assign right_c  = cell_q[i];
            assign right_ok = 1'b0;
        end
        else
        begin : g_mid
            assign right_c  = cell_q[i+1];
            assign right_ok = 1'b1;
        end

        smpd_cell u_cell (
            .clk      (clk),
            .ctl      (ctl),
            .init_age (AGE_W'(i)),
            .left_w   (left_w),
            .left_ok  (left_ok),
            .right_c  (right_c),
            .right_ok (right_ok),
            .del_in   (del_in),
            .cell_q   (cell_q[i]),
            .cell_n   (cell_n[i]),
            .w        (cell_w[i]),
            .w_ok     (w_ok[i]),
            .del_out  (del[i])
        );
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg    <= 1'b0;
            thr_reg       <= THRESHOLD_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                primed_reg <= 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                thr_reg <= cfg_data;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output word: middle cell after the update, and threshold compare
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            median_reg  <= cell_n[MID].val;
            pressed_reg <= (cell_n[MID].val < thr_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W - SAMPLE_W - 1){1'b0}}, pressed_reg, median_reg};

endmodule

// File: sv/smpd_cell.sv
`timescale 1ns / 1ps

// One slot of the sorted window. Cells stay in ascending order of value.
// On each word after priming the oldest entry drops out, the cells to
// its right close the gap, and the new sample is inserted in order.
module smpd_cell
    import smpd_pkg::*;
(
    input  logic             clk,
    input  cell_ctl_t        ctl,
    input  logic [AGE_W-1:0] init_age,
    input  cell_t            left_w,
    input  logic             left_ok,
    input  cell_t            right_c,
    input  logic             right_ok,
    input  logic             del_in,
    output cell_t            cell_q,
    output cell_t            cell_n,
    output cell_t            w,
    output logic             w_ok,
    output logic             del_out
);

    cell_t cell_reg;
    cell_t cell_next;
    logic  own_old;

    // Removal of the oldest entry, seen from this slot
    assign own_old = (cell_reg.age == ctl.age_max);
    assign del_out = del_in | own_old;
    assign w       = del_out ? right_c : cell_reg;
    assign w_ok    = right_ok;

    // Ordered insert of the new sample
    always_comb
    begin
        if (ctl.prime)
        begin
            cell_next.val = ctl.sample;
            cell_next.age = init_age;
        end
        else if (w_ok && (w.val <= ctl.sample))
        begin
            cell_next.val = w.val;
            cell_next.age = w.age + AGE_W'(1);
        end
        else if (left_ok && (left_w.val > ctl.sample))
        begin
            cell_next.val = left_w.val;
            cell_next.age = left_w.age + AGE_W'(1);
        end
        else
        begin
            cell_next.val = ctl.sample;
            cell_next.age = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            cell_reg <= cell_next;
        end
    end

    assign cell_q = cell_reg;
    assign cell_n = cell_next;

endmodule

// File: sv/smpd_checker.sv
`timescale 1ns / 1ps

module smpd_checker
    import smpd_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic             cfg_valid,
    input logic             cfg_ready
);

    // Stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // Every accepted sample yields a word on the next cycle
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("no result after accepted sample");

    // Empty or draining output never blocks the input
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid || m_tready |-> s_tready)
        else $error("input stalled with free output");

    // A word with no new sample cannot appear
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid ##1 m_tvalid |-> $past(s_tvalid && s_tready))
        else $error("result without sample");

    // Threshold register always takes writes
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("threshold write refused");

endmodule

bind sliding_median_press_detector smpd_checker u_smpd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

// File: sim/press_median_checker.sv
`timescale 1ns / 1ps
// Watches the sample, result and threshold channels of the median press
// detector, keeps its own copy of the window and the threshold, and compares
// every result word against the oldest prediction.
module press_median_checker
    import smpd_pkg::*;
#(
    parameter int WINDOW = 5
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [IN_W-1:0]     s_tdata,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [OUT_W-1:0]    m_tdata,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [SAMPLE_W-1:0] cfg_data,
    output int                  fail_count,
    output int                  pending
);

    typedef struct packed {
        logic [SAMPLE_W-1:0] median;
        logic                pressed;
    } press_word_t;

    press_word_t         expected_words [$];
    logic [SAMPLE_W-1:0] window_vals [WINDOW];
    int                  next_slot;
    logic                primed;
    logic [SAMPLE_W-1:0] threshold;

    // Middle entry of an ascending sort of the window
    function automatic logic [SAMPLE_W-1:0] window_median();
        logic [SAMPLE_W-1:0] sorted [WINDOW];
        logic [SAMPLE_W-1:0] key;
        int                  j;
        for (int i = 0; i < WINDOW; i++)
        begin
            sorted[i] = window_vals[i];
        end
        for (int i = 1; i < WINDOW; i++)
        begin
            key = sorted[i];
            j = i - 1;
            while (j >= 0 && sorted[j] > key)
            begin
                sorted[j + 1] = sorted[j];
                j--;
            end
            sorted[j + 1] = key;
        end
        return sorted[WINDOW / 2];
    endfunction

    // Fold one sample into the window and queue the word it should produce
    task automatic absorb_sample(input logic [SAMPLE_W-1:0] smp);
        press_word_t w;
        if (!primed)
        begin
            // first sample after reset floods the whole window
            for (int i = 0; i < WINDOW; i++)
            begin
                window_vals[i] = smp;
            end
            next_slot = 0;
            primed = 1'b1;
        end
        else
        begin
            window_vals[next_slot] = smp;
            next_slot = (next_slot + 1 >= WINDOW) ? 0 : next_slot + 1;
        end
        w.median  = window_median();
        w.pressed = (w.median < threshold);
        expected_words.push_back(w);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        press_word_t got;
        press_word_t want;
        if (!rst_n)
        begin
            expected_words.delete();
            for (int i = 0; i < WINDOW; i++)
            begin
                window_vals[i] = '0;
            end
            next_slot  = 0;
            primed     = 1'b0;
            threshold  = THRESHOLD_RESET;
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            // result side first; a sample taken at this edge answers later
            if (m_tvalid && m_tready)
            begin
                got.median  = m_tdata[SAMPLE_W-1:0];
                got.pressed = m_tdata[SAMPLE_W];
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected result word median=%0d pressed=%0b",
                             $time, got.median, got.pressed);
                    fail_count++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (got.median !== want.median)
                    begin
                        $display("%0t: median mismatch expected=%0d actual=%0d",
                                 $time, want.median, got.median);
                        fail_count++;
                    end
                    if (got.pressed !== want.pressed)
                    begin
                        $display("%0t: pressed mismatch expected=%0b actual=%0b",
                                 $time, want.pressed, got.pressed);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                threshold = cfg_data;
            end
            if (s_tvalid && s_tready)
            begin
                absorb_sample(s_tdata[SAMPLE_W-1:0]);
            end
            pending = expected_words.size();
        end
    end

endmodule

// File: sim/tb_sliding_median_press_detector.sv
`timescale 1ns / 1ps
module tb_sliding_median_press_detector;
    import smpd_pkg::*;

    localparam int WINDOW      = 5;
    localparam int CYCLE_LIMIT = 200000;
    localparam int BLOCKS      = 9;
    localparam int BLOCK_ITEMS = 110;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_W-1:0]    m_tdata;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [SAMPLE_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int send_idle_pct;
    int recv_stall_pct;
    int cycle_count;
    int cur_threshold;
    int prev_sample;

    sliding_median_press_detector #(.WINDOW(WINDOW)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    press_median_checker #(.WINDOW(WINDOW)) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Receiver stalls at random, rate set per phase
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("sliding_median_press_detector verification failed");
        $finish;
    end

    // Called at a falling edge; returns at a falling edge with tvalid still high
    task automatic send_sample(input int value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = IN_W'(value);
        prev_sample = value;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Stop sending and wait until every predicted word has come out
    task automatic drain_results();
        s_tvalid = 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (3) @(negedge clk);
    endtask

    task automatic write_threshold(input int value);
        cfg_valid = 1'b1;
        cfg_data  = SAMPLE_W'(value);
        cur_threshold = value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Random sample: uniform four times in ten, plus clusters around the threshold,
    // the rails, repeats and narrow low / high bands
    function automatic int pick_sample();
        int v;
        case ($urandom_range(9))
            4, 5:
            begin
                v = cur_threshold + $urandom_range(8) - 4;
                if (v < 0) v = 0;
                if (v > 1023) v = 1023;
            end
            6:       v = $urandom_range(1) ? 1023 : 0;
            7:       v = prev_sample;
            8:       v = $urandom_range(63);
            9:       v = 960 + $urandom_range(63);
            default: v = $urandom_range(1023);
        endcase
        return v;
    endfunction

    initial
    begin
        int directed_a [12];
        int directed_c [5];
        int thr;
        int pause_at;

        directed_a     = '{1023, 0, 0, 599, 600, 601, 600, 600, 600, 599, 599, 599};
        directed_c     = '{1023, 1023, 1023, 1022, 1022};
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cur_threshold  = 600;
        prev_sample    = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: window fill on the first sample, medians around the
        // reset threshold of 600
        foreach (directed_a[i])
        begin
            send_sample(directed_a[i]);
        end
        // zero threshold never reports pressed
        drain_results();
        write_threshold(0);
        repeat (3) send_sample(0);
        // top threshold: only a full-scale median is not pressed
        drain_results();
        write_threshold(1023);
        foreach (directed_c[i])
        begin
            send_sample(directed_c[i]);
        end

        // Random blocks, each with its own threshold; the idling profile changes every third block
        for (int blk = 0; blk < BLOCKS; blk++)
        begin
            drain_results();
            if (blk < 3)
            begin
                send_idle_pct  = 10;
                recv_stall_pct = 56;
            end
            else if (blk < 6)
            begin
                send_idle_pct  = 56;
                recv_stall_pct = 10;
            end
            else
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            case (blk)
                0:       thr = 0;
                1:       thr = 1023;
                4:       thr = 1;
                7:       thr = 1022;
                default: thr = $urandom_range(1023);
            endcase
            write_threshold(thr);
            pause_at = $urandom_range(BLOCK_ITEMS - 1);
            for (int n = 0; n < BLOCK_ITEMS; n++)
            begin
                if (n == pause_at)
                begin
                    drain_results();
                end
                send_sample(pick_sample());
            end
        end

        drain_results();
        repeat (5) @(negedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("sliding_median_press_detector verification clean");
        end
        else
        begin
            $display("sliding_median_press_detector verification failed");
        end
        $finish;
    end

endmodule

// File: files.f
sv/smpd_pkg.sv
sv/smpd_cell.sv
sv/sliding_median_press_detector.sv
sv/smpd_checker.sv
sim/press_median_checker.sv
sim/tb_sliding_median_press_detector.sv
